// File: design/kft_pkg.sv
// ----------------------------------------------------------------------------
// kft_pkg - shared types and constants for the key frequency table
// Holds the table size, derived widths, the token that walks the cell row
// and the helper that folds an entry index into the result slot field.
// ----------------------------------------------------------------------------
package kft_pkg;

  // Number of table entries, one cell each (range 2 to 4096)
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned OUT_W   = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Token handed from cell to cell, one per clock while the row advances
  typedef struct packed {
    logic                    vld;      // token carries a key
    logic                    start;    // table is emptied ahead of this key
    logic                    done;     // key already matched or appended
    logic                    was_new;  // key was appended as a new entry
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        idx;      // entry that took the key
    logic [CNT_W-1:0]        cnt;      // count after this key
  } kft_tok_t;

  // Report the low bits of an entry index in the slot field
  function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// File: design/kft_cell.sv
// ----------------------------------------------------------------------------
// kft_cell - one table entry of the key frequency table
// Holds one key and its count. Compares the passing token's key, bumps the
// count on a hit or takes the key when the entry is free, and registers the
// token for the next cell.
// ----------------------------------------------------------------------------
module kft_cell
  import kft_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,        // whole row advances this cycle
  input  logic [IDX_W-1:0] cell_idx,   // position of this cell in the row
  input  kft_tok_t         tok_i,
  output kft_tok_t         tok_o
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  kft_tok_t         tok_r, tok_nxt;

  logic             eff_valid;
  logic             hit;
  logic [CNT_W-1:0] cnt_inc;

  // Match, append or pass the token on
  always_comb begin
    tok_nxt   = tok_i;
    valid_nxt = valid_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    eff_valid = valid_r && !tok_i.start;
    hit       = eff_valid && (key_r == tok_i.key);
    cnt_inc   = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_ONE;
    if (tok_i.vld) begin
      valid_nxt = eff_valid;
      if (!tok_i.done) begin
        if (hit) begin
          cnt_nxt      = cnt_inc;
          tok_nxt.done = 1'b1;
          tok_nxt.idx  = cell_idx;
          tok_nxt.cnt  = cnt_inc;
        end else if (!eff_valid) begin
          valid_nxt       = 1'b1;
          key_nxt         = tok_i.key;
          cnt_nxt         = CNT_ONE;
          tok_nxt.done    = 1'b1;
          tok_nxt.was_new = 1'b1;
          tok_nxt.idx     = cell_idx;
          tok_nxt.cnt     = CNT_ONE;
        end
      end
    end
  end

  // Hold entry valid flag and token on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  // Entry payload, no reset
  always_ff @(posedge clk) begin
    if (adv) begin
      key_r <= key_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// File: design/key_frequency_table_unit.sv
// ----------------------------------------------------------------------------
// key_frequency_table_unit - streaming key frequency counter
// Counts occurrences of 32-bit signed keys in a table kept in order of first
// appearance, one cell per entry.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry a key on in_tdata and a start flag on in_tuser; a set
//   flag empties the table before that key is counted. Every input beat
//   yields exactly one output beat: slot, new count, new flag and overflow.
//   Each key walks the row of TABLE_ENTRIES cells, one cell per cycle while
//   the row advances, and its result leaves the last cell's token register.
//   Keys follow each other in the row, so one beat is taken every cycle
//   while the output is not stalled; a later key meets each cell after the
//   earlier key has already updated it.
//   The last cell's token register is the output register. While a result
//   waits there unread the whole row holds and in_tready is low.
//   Reset empties the table and the row at once; no clearing pass.
// ----------------------------------------------------------------------------
module key_frequency_table_unit
  import kft_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [KEY_W-1:0]    in_tdata,   // [31:0] key
  input  logic                in_tuser,   // [0] start_new
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata   // [5:0] slot, [37:6] new_count,
                                          // [38] was_new, [39] overflow
);

  kft_tok_t chain [0:TABLE_ENTRIES];
  kft_tok_t last_tok;
  logic     adv;
  logic     dropped;

  // Advance the row unless a result is stuck at the output
  assign adv       = !last_tok.vld || out_tready;
  assign in_tready = adv;

  // Build the entry token from the input beat
  always_comb begin
    chain[0]         = '0;
    chain[0].vld     = in_tvalid;
    chain[0].start   = in_tuser;
    chain[0].key     = in_tdata;
  end

  // Row of table cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    kft_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_idx (IDX_W'(g)),
      .tok_i    (chain[g]),
      .tok_o    (chain[g+1])
    );
  end

  assign last_tok = chain[TABLE_ENTRIES];

  // Format the result beat; a key that found no place is dropped
  assign dropped    = !last_tok.done;
  assign out_tvalid = last_tok.vld;
  assign out_tdata  = {dropped,
                       last_tok.was_new,
                       dropped ? '0 : last_tok.cnt,
                       dropped ? '0 : slot_of(last_tok.idx)};

endmodule

// File: design/kft_checker.sv
// ----------------------------------------------------------------------------
// kft_checker - port-level checks for the key frequency table
// Watches the result channel for consistent flag and field combinations.
// ----------------------------------------------------------------------------
module kft_checker
  import kft_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata
);

  // Stalled result beat holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  // Dropped key reports an empty slot and count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[39] |->
      out_tdata[5:0] == 6'd0 && out_tdata[37:6] == 32'd0 && !out_tdata[38])
    else $error("overflow beat carries data");

  // New entry always starts at count one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[38] |-> out_tdata[37:6] == 32'd1 && !out_tdata[39])
    else $error("new entry with bad count");

  // Counted key never reports zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[39] |-> out_tdata[37:6] != 32'd0)
    else $error("counted key with zero count");

endmodule

bind key_frequency_table_unit kft_checker u_kft_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
